// File: hdl/pmsu_pkg.sv
package pmsu_pkg;

   localparam int SITES     = 4096;
   localparam int NEIGHBORS = 8;
   localparam int STATES    = 8;

   localparam int NUM_THRESH = 8;

   // fixed field widths
   localparam int OP_W     = 2;
   localparam int SITE_W   = 12;
   localparam int SLOT_W   = 3;
   localparam int SPIN_W   = 3;
   localparam int DRAW_W   = 16;
   localparam int STATUS_W = 2;
   localparam int DELTA_W  = 5;
   localparam int ENERGY_W = 16;
   localparam int THRESH_W = 16;
   localparam int CSR_IDX_W = 3;

   // storage geometry
   localparam int SITE_AW = $clog2(SITES);
   localparam int NBR_DEPTH = SITES * NEIGHBORS;
   localparam int NBR_AW = $clog2(NBR_DEPTH);
   localparam int STEP_W = $clog2(NEIGHBORS + 1);

   typedef logic [OP_W-1:0]     opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam opcode_type OP_LOAD_NBR   = 2'd0;
   localparam opcode_type OP_WRITE_SPIN = 2'd1;
   localparam opcode_type OP_FLIP       = 2'd2;
   localparam opcode_type OP_NONE       = 2'd3;

   localparam status_type ST_ACCEPT = 2'd0;
   localparam status_type ST_REJECT = 2'd1;
   localparam status_type ST_EQUAL  = 2'd2;
   localparam status_type ST_DONE   = 2'd3;

   function automatic logic [NBR_AW-1:0] nbr_addr(input logic [SITE_W-1:0] site_idx,
                                                  input logic [SLOT_W-1:0] slot_idx);
      return NBR_AW'(int'(site_idx) * NEIGHBORS + int'(slot_idx));
   endfunction

endpackage

// File: hdl/pmsu_ram.sv
module pmsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/potts_metropolis_spin_update_unit.sv
// Metropolis spin update for a Potts lattice held in two single-port-read RAMs:
// one spin per site and a table of neighbour site indices per site. Neighbour
// loads, spin writes and unused opcodes finish in the cycle of the transfer and
// answer in the next cycle. A flip proposal that reaches the acceptance test
// first reads the site's own spin, then the spin of each neighbour slot in turn,
// as the single read port of the spin RAM is shared between the old-spin read
// and the neighbour-spin reads, and then does the acceptance test and
// write-back before its answer. A proposal equal to the current spin answers
// from the first scan step, and one with site or spin out of range answers in
// the cycle after the transfer. One item is in flight at a time; the next
// transfer is taken once the result register is empty or being emptied.
// Acceptance thresholds may be written only while idle.
module potts_metropolis_spin_update_unit
   import pmsu_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [THRESH_W-1:0]        csr_wdata,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_W-1:0]            req_opcode,
   input  logic [SITE_W-1:0]          req_site,
   input  logic [SLOT_W-1:0]          req_slot,
   input  logic [SITE_W-1:0]          req_neighbor_site,
   input  logic [SPIN_W-1:0]          req_spin_value,
   input  logic [DRAW_W-1:0]          req_uniform_draw,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DELTA_W-1:0]  rsp_energy_delta,
   output logic signed [ENERGY_W-1:0] rsp_energy_total
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [SITE_W-1:0]          site_ff, site_in;
   logic [SPIN_W-1:0]          spin_ff, spin_in;
   logic [DRAW_W-1:0]          draw_ff, draw_in;
   logic [SPIN_W-1:0]          old_ff, old_in;
   logic signed [DELTA_W-1:0]  d_ff, d_in;
   logic                       nvalid_ff, nvalid_in;
   logic [THRESH_W-1:0]        thresh_ff [NUM_THRESH];
   logic signed [ENERGY_W-1:0] energy_ff, energy_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic signed [DELTA_W-1:0]  rsp_delta_ff, rsp_delta_in;

   logic                       req_xfer;
   logic                       site_ok, spin_ok, slot_ok;
   logic [SLOT_W-1:0]          next_slot;
   logic [$clog2(NUM_THRESH)-1:0] thresh_idx;
   logic                       flip_accept;

   logic                       spin_we;
   logic [SITE_AW-1:0]         spin_waddr, spin_raddr;
   logic [SPIN_W-1:0]          spin_wdata, spin_rdata;
   logic                       nbr_we;
   logic [NBR_AW-1:0]          nbr_waddr, nbr_raddr;
   logic [SITE_W-1:0]          nbr_rdata;

   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_xfer  = req_valid && !req_stall;

   assign site_ok = int'(req_site) < SITES;
   assign spin_ok = int'(req_spin_value) < STATES;
   assign slot_ok = int'(req_slot) < NEIGHBORS;

   assign next_slot = (int'(step_ff) + 1 < NEIGHBORS) ? SLOT_W'(int'(step_ff) + 1) : '0;

   // d is 1..NUM_THRESH here; table entry d-1
   assign thresh_idx  = $clog2(NUM_THRESH)'(d_ff - DELTA_W'(1));
   assign flip_accept = (d_ff <= 0) || (draw_ff < thresh_ff[thresh_idx]);

   // memory ports
   always_comb begin
      spin_raddr = SITE_AW'(req_site);
      nbr_raddr  = nbr_addr(req_site, '0);
      if (state_ff == S_SCAN) begin
         spin_raddr = SITE_AW'(nbr_rdata);
         nbr_raddr  = nbr_addr(site_ff, next_slot);
      end
   end

   always_comb begin
      nbr_we    = req_xfer && (req_opcode == OP_LOAD_NBR) && site_ok && slot_ok;
      nbr_waddr = nbr_addr(req_site, req_slot);
      if (state_ff == S_DECIDE) begin
         spin_we    = flip_accept;
         spin_waddr = SITE_AW'(site_ff);
         spin_wdata = spin_ff;
      end else begin
         spin_we    = req_xfer && (req_opcode == OP_WRITE_SPIN) && site_ok && spin_ok;
         spin_waddr = SITE_AW'(req_site);
         spin_wdata = req_spin_value;
      end
   end

   pmsu_ram #(
      .WIDTH (SPIN_W),
      .DEPTH (SITES)
   ) u_spin_ram (
      .clock (clock),
      .we    (spin_we),
      .waddr (spin_waddr),
      .wdata (spin_wdata),
      .raddr (spin_raddr),
      .rdata (spin_rdata)
   );

   pmsu_ram #(
      .WIDTH (SITE_W),
      .DEPTH (NBR_DEPTH)
   ) u_nbr_ram (
      .clock (clock),
      .we    (nbr_we),
      .waddr (nbr_waddr),
      .wdata (req_neighbor_site),
      .raddr (nbr_raddr),
      .rdata (nbr_rdata)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      site_in       = site_ff;
      spin_in       = spin_ff;
      draw_in       = draw_ff;
      old_in        = old_ff;
      d_in          = d_ff;
      nvalid_in     = nvalid_ff;
      energy_in     = energy_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_delta_in  = rsp_delta_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               site_in = req_site;
               spin_in = req_spin_value;
               draw_in = req_uniform_draw;
               d_in    = '0;
               step_in = '0;
               if (req_opcode == OP_FLIP) begin
                  if (site_ok && spin_ok) begin
                     state_in = S_SCAN;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_REJECT;
                     rsp_delta_in  = '0;
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_DONE;
                  rsp_delta_in  = '0;
               end
            end
         end
         S_SCAN: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == '0) begin
               // own spin arrives together with neighbour slot 0
               old_in = spin_rdata;
               if (spin_rdata == spin_ff) begin
                  state_in      = S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EQUAL;
                  rsp_delta_in  = '0;
               end
            end else if (nvalid_ff) begin
               if (spin_rdata == old_ff) begin
                  d_in = d_ff - DELTA_W'(1);
               end else if (spin_rdata == spin_ff) begin
                  d_in = d_ff + DELTA_W'(1);
               end
            end
            nvalid_in = int'(nbr_rdata) < SITES;
            if (int'(step_ff) == NEIGHBORS) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_delta_in = d_ff;
            if (flip_accept) begin
               rsp_status_in = ST_ACCEPT;
               energy_in     = energy_ff + ENERGY_W'(d_ff);
            end else begin
               rsp_status_in = ST_REJECT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         energy_ff    <= '0;
         for (int i = 0; i < NUM_THRESH; i++) begin
            thresh_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         energy_ff    <= energy_in;
         if (csr_we) begin
            thresh_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      site_ff       <= site_in;
      spin_ff       <= spin_in;
      draw_ff       <= draw_in;
      old_ff        <= old_in;
      d_ff          <= d_in;
      nvalid_ff     <= nvalid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_delta_ff  <= rsp_delta_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_energy_delta = rsp_delta_ff;
   assign rsp_energy_total = energy_ff;

`ifndef SYNTHESIS
   a_xfer_progress: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (rsp_valid_ff || state_ff != S_IDLE))
      else $error("transfer produced neither a result nor work");

   a_decide_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("acceptance test gave no result");

   a_energy_only_on_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DECIDE) |=> $stable(energy_ff))
      else $error("energy sum moved outside acceptance step");

   a_zero_delta: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_EQUAL || rsp_status_ff == ST_DONE))
         |-> (rsp_delta_ff == '0))
      else $error("non-flip result carries an energy change");

   a_accept_rule: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && d_ff <= 0) |=> (rsp_status_ff == ST_ACCEPT))
      else $error("flip lowering energy was rejected");
`endif

endmodule
